// ===== src/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent, checked at every rising edge out of reset
`define SHIP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ship implication check failed");
// expression must never hold at a rising edge out of reset
`define SHIP_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ship forbidden condition seen");
`else
`define SHIP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHIP_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== src/ship_pkg.sv =====
// shared constants, line and row types, controller to datapath structs
package ship_pkg;

    localparam int CORES         = 1;
    localparam int SETS          = 2048;
    localparam int WAYS          = 16;
    // power of two: the signature is the low bits of the folded pc
    localparam int TABLE_ENTRIES = 4096;
    localparam int RRPV_WIDTH    = 2;
    localparam int COUNTER_WIDTH = 3;

    localparam int ROWS      = CORES * SETS;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int SIG_W     = $clog2(TABLE_ENTRIES);
    localparam int CLR_DEPTH = (ROWS > TABLE_ENTRIES) ? ROWS : TABLE_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    localparam logic [RRPV_WIDTH-1:0]    RRPV_MAX   = {RRPV_WIDTH{1'b1}};
    localparam logic [COUNTER_WIDTH-1:0] CTR_MAX    = {COUNTER_WIDTH{1'b1}};
    localparam logic [COUNTER_WIDTH-1:0] CTR_THRESH = CTR_MAX >> 1;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic [SIG_W-1:0]      sig;
        logic                  reused;
        logic                  valid;
        logic [RRPV_WIDTH-1:0] rrpv;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    localparam line_t LINE_RESET = '{sig: '0, reused: 1'b0, valid: 1'b0, rrpv: RRPV_MAX};

    typedef struct packed {
        logic clear;
        logic load;
        logic row_read;
        logic decide;
        logic train;
        logic install;
    } ship_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_train;
    } ship_stat_t;

endpackage

// ===== src/ship_ram.sv =====
// generic single write port ram with registered read
module ship_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ship_ctrl.sv =====
// sequencing state machine: clear pass, row read, decide, train, install
module ship_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  ship_pkg::ship_stat_t   stat,
    output ship_pkg::ship_cmd_t    cmd,
    output logic                   busy
);
    import ship_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_READ    = 6'b000100,
        ST_DECIDE  = 6'b001000,
        ST_TRAIN   = 6'b010000,
        ST_INSTALL = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (stat.clear_last) state_next = ST_IDLE;
            ST_IDLE:    if (start) state_next = ST_READ;
            ST_READ:    state_next = ST_DECIDE;
            ST_DECIDE:  state_next = stat.need_train ? ST_TRAIN : ST_IDLE;
            ST_TRAIN:   state_next = ST_INSTALL;
            ST_INSTALL: state_next = ST_IDLE;
            default:    state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.clear    = (state_reg == ST_CLEAR);
        cmd.load     = (state_reg == ST_IDLE) && start;
        cmd.row_read = (state_reg == ST_READ);
        cmd.decide   = (state_reg == ST_DECIDE);
        cmd.train    = (state_reg == ST_TRAIN);
        cmd.install  = (state_reg == ST_INSTALL);
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== src/ship_dp.sv =====
// datapath: request registers, set row ram, reuse counter ram, victim and update logic
module ship_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ship_pkg::ship_cmd_t  cmd,
    output ship_pkg::ship_stat_t stat,
    input  logic                 op,
    input  logic [1:0]           core_index,
    input  logic [10:0]          set_index,
    input  logic [3:0]           way_index,
    input  logic [14:0]          pc_low,
    input  logic                 was_hit,
    output logic                 done,
    output logic [3:0]           victim_way,
    output logic                 is_victim_reply
);
    import ship_pkg::*;

    // request registers
    logic              req_op_reg;
    logic              req_hit_reg;
    logic              req_in_range_reg;
    logic [ROW_AW-1:0] req_row_reg;
    logic [3:0]        req_way_reg;
    logic [SIG_W-1:0]  req_sig_reg;
    logic [14:0]       pc_mix;

    // miss path holding registers
    row_t                     row_hold_reg;
    logic [SIG_W-1:0]         old_sig_reg;
    logic                     old_valid_reg;
    logic                     old_reused_reg;
    logic [COUNTER_WIDTH-1:0] trained_reg;
    logic                     fwd_reg;

    // clear sweep and result registers
    logic [CLR_W-1:0] clr_cnt_reg;
    logic             done_reg;
    logic             done_next;
    logic [3:0]       victim_way_reg;
    logic [3:0]       victim_way_next;
    logic             is_victim_reply_reg;

    // ram ports
    logic              row_we;
    logic [ROW_AW-1:0] row_waddr;
    logic [ROW_W-1:0]  row_wdata;
    logic [ROW_W-1:0]  row_rdata;
    row_t              row_cur;

    logic                     ctr_we;
    logic [SIG_W-1:0]         ctr_waddr;
    logic [COUNTER_WIDTH-1:0] ctr_wdata;
    logic                     ctr_re;
    logic [SIG_W-1:0]         ctr_raddr;
    logic [COUNTER_WIDTH-1:0] ctr_rdata;

    // decide stage values
    logic                     way_ok;
    logic [WAY_W-1:0]         way_sel;
    line_t                    old_line;
    logic                     any_inv;
    logic [WAY_W-1:0]         inv_way;
    logic [WAYS-1:0]          cand;
    logic [WAYS-1:0]          bitv;
    logic [RRPV_WIDTH-1:0]    top;
    logic [RRPV_WIDTH-1:0]    delta;
    logic [WAY_W-1:0]         max_way;
    logic [WAY_W-1:0]         victim;
    row_t                     aged_row;
    row_t                     hit_row;
    row_t                     inst_row;
    row_t                     clr_row;
    logic [COUNTER_WIDTH-1:0] trained;
    logic [COUNTER_WIDTH-1:0] ins_ctr;
    logic [RRPV_WIDTH-1:0]    ins_rrpv;

    assign pc_mix = pc_low ^ (pc_low >> 3);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_op_reg       <= op;
            req_hit_reg      <= was_hit;
            req_in_range_reg <= (int'(core_index) < CORES) && (int'(set_index) < SETS);
            req_row_reg      <= ROW_AW'(int'(core_index) * SETS + int'(set_index));
            req_way_reg      <= way_index;
            req_sig_reg      <= SIG_W'(pc_mix);
        end
        if (cmd.decide)
        begin
            row_hold_reg   <= row_cur;
            old_sig_reg    <= old_line.sig;
            old_valid_reg  <= old_line.valid;
            old_reused_reg <= old_line.reused;
        end
        if (cmd.train)
        begin
            trained_reg <= trained;
            fwd_reg     <= old_valid_reg && (old_sig_reg == req_sig_reg);
        end
        if (done_next)
        begin
            victim_way_reg      <= victim_way_next;
            is_victim_reply_reg <= (req_op_reg == OP_QUERY);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            done_reg <= done_next;
        end
    end

    assign row_cur  = row_rdata;
    assign way_ok   = int'(req_way_reg) < WAYS;
    assign way_sel  = WAY_W'(req_way_reg);
    assign old_line = row_cur[way_sel];

    // first invalid way, and the ways holding the largest rrpv, msb first
    always_comb
    begin
        any_inv = 1'b0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!row_cur[w].valid)
            begin
                any_inv = 1'b1;
                inv_way = WAY_W'(w);
            end
        end

        cand = '1;
        top  = '0;
        bitv = '0;
        for (int b = RRPV_WIDTH - 1; b >= 0; b--)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                bitv[w] = row_cur[w].rrpv[b];
            end
            if (|(cand & bitv))
            begin
                cand   = cand & bitv;
                top[b] = 1'b1;
            end
        end

        max_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (cand[w])
            begin
                max_way = WAY_W'(w);
            end
        end

        delta    = RRPV_MAX - top;
        aged_row = row_cur;
        for (int w = 0; w < WAYS; w++)
        begin
            aged_row[w].rrpv = row_cur[w].rrpv + delta;
            clr_row[w]       = LINE_RESET;
        end

        victim = any_inv ? inv_way : max_way;
    end

    // hit, train and install values
    always_comb
    begin
        hit_row                 = row_cur;
        hit_row[way_sel].rrpv   = '0;
        hit_row[way_sel].valid  = 1'b1;
        hit_row[way_sel].reused = 1'b1;

        if (old_reused_reg)
        begin
            trained = (ctr_rdata != CTR_MAX) ? ctr_rdata + COUNTER_WIDTH'(1) : ctr_rdata;
        end
        else
        begin
            trained = (ctr_rdata != '0) ? ctr_rdata - COUNTER_WIDTH'(1) : ctr_rdata;
        end

        ins_ctr  = fwd_reg ? trained_reg : ctr_rdata;
        ins_rrpv = (ins_ctr >= CTR_THRESH) ? RRPV_MAX - RRPV_WIDTH'(1) : RRPV_MAX;

        inst_row          = row_hold_reg;
        inst_row[way_sel] = '{sig: req_sig_reg, reused: 1'b0, valid: 1'b1, rrpv: ins_rrpv};
    end

    // row ram write selection
    always_comb
    begin
        row_we    = 1'b0;
        row_waddr = req_row_reg;
        row_wdata = hit_row;
        if (cmd.clear)
        begin
            row_we    = int'(clr_cnt_reg) < ROWS;
            row_waddr = clr_cnt_reg[ROW_AW-1:0];
            row_wdata = clr_row;
        end
        else if (cmd.decide)
        begin
            if (req_op_reg == OP_QUERY)
            begin
                row_we    = req_in_range_reg && !any_inv;
                row_wdata = aged_row;
            end
            else
            begin
                row_we    = req_in_range_reg && way_ok && req_hit_reg;
                row_wdata = hit_row;
            end
        end
        else if (cmd.install)
        begin
            row_we    = 1'b1;
            row_wdata = inst_row;
        end
    end

    // counter ram selection
    always_comb
    begin
        ctr_we    = 1'b0;
        ctr_waddr = old_sig_reg;
        ctr_wdata = trained;
        ctr_re    = 1'b0;
        ctr_raddr = req_sig_reg;
        if (cmd.clear)
        begin
            ctr_we    = int'(clr_cnt_reg) < TABLE_ENTRIES;
            ctr_waddr = clr_cnt_reg[SIG_W-1:0];
            ctr_wdata = CTR_THRESH;
        end
        else if (cmd.decide)
        begin
            ctr_re    = stat.need_train;
            ctr_raddr = old_line.sig;
        end
        else if (cmd.train)
        begin
            ctr_we = old_valid_reg;
            ctr_re = 1'b1;
        end
    end

    ship_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (cmd.row_read),
        .raddr (req_row_reg),
        .rdata (row_rdata)
    );

    ship_ram #(
        .WIDTH (COUNTER_WIDTH),
        .DEPTH (TABLE_ENTRIES)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (ctr_re),
        .raddr (ctr_raddr),
        .rdata (ctr_rdata)
    );

    assign stat.clear_last = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));
    assign stat.need_train = (req_op_reg == OP_UPDATE) && req_in_range_reg && way_ok
                             && !req_hit_reg;

    assign done_next       = (cmd.decide && !stat.need_train) || cmd.install;
    assign victim_way_next = ((req_op_reg == OP_QUERY) && req_in_range_reg) ? 4'(victim) : 4'b0;

    assign done            = done_reg;
    assign victim_way      = victim_way_reg;
    assign is_victim_reply = is_victim_reply_reg;

endmodule

// ===== src/ship_srrip_replacement_unit.sv =====
// top level of the signature based srrip replacement unit
//
// A transaction is taken at a rising edge with start high and busy low. Each
// transaction gives exactly one result, shown for one cycle with done high;
// the receiver cannot hold it off, so it must take it in that cycle. A victim
// query, a hit update, or an update outside the configured cores and sets
// goes through row read, row data back, and decide and write back before
// done, and the next transaction can be taken in the cycle that done is
// shown. A miss update that fills a line adds a train and an install step
// after decide. The extra steps come from the reuse counter ram, which has one
// read port: the evicted signature's counter and the new signature's counter
// are read one after the other.
// After reset the unit sweeps both rams, one address per cycle, through 4096
// addresses (the larger of the set row count and the counter table size) with
// busy high; no transaction is taken during that sweep.
`include "assert_macros.svh"

module ship_srrip_replacement_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [1:0]  core_index,
    input  logic [10:0] set_index,
    input  logic [3:0]  way_index,
    input  logic [14:0] pc_low,
    input  logic        was_hit,
    output logic        done,
    output logic [3:0]  victim_way,
    output logic        is_victim_reply
);
    import ship_pkg::*;

    // command and status between sequencer and datapath
    ship_cmd_t  cmd;
    ship_stat_t stat;

    // sequencer: clear sweep, then idle / read / decide / train / install
    ship_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath: set row ram holds rrpv, valid, reused and signature per way;
    // counter ram holds the per signature reuse counters
    ship_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .op              (op),
        .core_index      (core_index),
        .set_index       (set_index),
        .way_index       (way_index),
        .pc_low          (pc_low),
        .was_hit         (was_hit),
        .done            (done),
        .victim_way      (victim_way),
        .is_victim_reply (is_victim_reply)
    );

    // only one datapath command per cycle
    `SHIP_ASSERT_NEVER(a_cmd_excl, clk, rst_n, !$onehot0(cmd))
    // a result only appears once the sequencer is back in idle
    `SHIP_ASSERT_NEVER(a_done_idle, clk, rst_n, done && busy)
    // the result strobe lasts one cycle
    `SHIP_ASSERT_IMPL(a_done_pulse, clk, rst_n, done, ##1 !done)
    // a victim query is answered with done and the victim reply flag
    `SHIP_ASSERT_IMPL(a_query_lat, clk, rst_n, start && !busy && op == OP_QUERY, ##3 (done && is_victim_reply))

endmodule
